// ===== rtl/sba_pkg.sv =====
// sba_pkg: shared types, field widths and operation codes for the sector
// bitmap allocator. No dependencies; used by every rtl file by scoped names.
package sba_pkg;

    localparam int FUNC_W      = 2;
    localparam int SECTOR_W    = 12;
    localparam int CFG_W       = 13;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    localparam int DEF_NUM_SECTORS = 4096;
    localparam int DEF_WORD_BITS   = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;      // write zero word at clear pointer
        logic load;          // latch input transaction, issue first read
        logic scan_next;     // skip full word, read the next one
        logic alloc_commit;  // set found bit, load result
        logic alloc_full;    // load "no free sector" result
        logic idx_commit;    // read-modify-write of addressed bit (release/mark), load result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic scan_skip;
        logic scan_hit;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/sba_ctrl.sv =====
// sba_ctrl: sequencing state machine of the sector bitmap allocator.
// Depends on sba_pkg (cmd_t, sts_t, operation codes).
module sba_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sba_pkg::FUNC_W-1:0] in_func,
    output logic                       in_ready,
    input  sba_pkg::sts_t              sts,
    output sba_pkg::cmd_t              cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_MOD   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_func == sba_pkg::FUNC_ALLOC) ? ST_SCAN : ST_MOD;
                end
            end
            ST_SCAN:
            begin
                // full words are skipped even while the result slot is busy
                if (sts.scan_skip)
                begin
                    cmd.scan_next = 1'b1;
                end
                else if (sts.out_free)
                begin
                    if (sts.scan_hit)
                    begin
                        cmd.alloc_commit = 1'b1;
                    end
                    else
                    begin
                        cmd.alloc_full = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (sts.out_free)
                begin
                    cmd.idx_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sba_dpath.sv =====
// sba_dpath: bitmap memory, config register, scan logic and result register.
// Depends on sba_pkg; driven by sba_ctrl through cmd_t / sts_t.
module sba_dpath
#(
    parameter int NUM_SECTORS = sba_pkg::DEF_NUM_SECTORS,
    parameter int WORD_BITS   = sba_pkg::DEF_WORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [sba_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [sba_pkg::FUNC_W-1:0]   in_func,
    input  logic [sba_pkg::SECTOR_W-1:0] in_sector,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [sba_pkg::SECTOR_W-1:0] out_sector,
    output logic                         out_ok,
    output logic                         out_was_used,
    input  sba_pkg::cmd_t                cmd,
    output sba_pkg::sts_t                sts
);

    localparam int NUM_WORDS = (NUM_SECTORS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WB_W      = $clog2(WORD_BITS + 1);
    localparam int NS_W      = $clog2(NUM_SECTORS + 1);
    localparam int LIM_W     = (NS_W > sba_pkg::CFG_W) ? NS_W : sba_pkg::CFG_W;
    localparam int BASE_W    = LIM_W + 1;
    // sector / WORD_BITS as multiply by a rounded-up reciprocal, exact for
    // every SECTOR_W-bit sector
    localparam int DSH       = sba_pkg::SECTOR_W + BIT_W;
    localparam int RW        = DSH + 1;
    localparam int RECIP     = ((1 << DSH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PRW       = sba_pkg::SECTOR_W + RW;
    localparam int PW        = WA_W + WB_W;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [sba_pkg::CFG_W-1:0]    data_sectors_reg;
    logic [WA_W-1:0]              clr_addr_reg;
    logic [sba_pkg::FUNC_W-1:0]   func_reg;
    logic [sba_pkg::SECTOR_W-1:0] sector_reg;
    logic [WA_W-1:0]              q_reg;
    logic                         in_range_reg;
    logic [WA_W-1:0]              scan_w_reg;
    logic [BASE_W-1:0]            base_reg;
    logic [WORD_BITS-1:0]         rd_data_reg;
    logic                         m_valid_reg;
    logic [sba_pkg::SECTOR_W-1:0] out_sector_reg;
    logic                         out_ok_reg;
    logic                         out_used_reg;

    logic [LIM_W-1:0]     lim;
    logic [PRW-1:0]       prod;
    logic [WA_W-1:0]      q_in;
    logic                 range_in;
    logic [WORD_BITS-1:0] free_bits;
    logic                 hit;
    logic [BIT_W-1:0]     hit_b;
    logic [WORD_BITS-1:0] hit_mask;
    logic                 base_in;
    logic [PW-1:0]        qw;
    logic [PW-1:0]        rem;
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 old_bit;
    logic [BASE_W-1:0]    found_idx;
    logic                 we;
    logic [WA_W-1:0]      wa;
    logic [WORD_BITS-1:0] wd;
    logic                 re;
    logic [WA_W-1:0]      ra;
    logic                 out_load;

    assign lim = (LIM_W'(data_sectors_reg) > LIM_W'(NUM_SECTORS))
               ? LIM_W'(NUM_SECTORS) : LIM_W'(data_sectors_reg);

    assign prod     = PRW'(in_sector) * PRW'(RECIP);
    assign q_in     = prod[DSH +: WA_W];
    assign range_in = LIM_W'(in_sector) < lim;

    // scan of the registered read word
    always_comb
    begin
        hit   = 1'b0;
        hit_b = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = !rd_data_reg[b] && ((base_reg + BASE_W'(b)) < BASE_W'(lim));
        end
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                hit   = 1'b1;
                hit_b = BIT_W'(b);
            end
        end
    end

    assign hit_mask  = WORD_BITS'(1) << hit_b;
    assign base_in   = base_reg < BASE_W'(lim);
    assign found_idx = base_reg + BASE_W'(hit_b);

    // bit position of an addressed sector from the registered word index
    assign qw       = PW'(q_reg) * PW'(WORD_BITS);
    assign rem      = PW'(sector_reg) - qw;
    assign bit_idx  = rem[BIT_W-1:0];
    assign bit_mask = WORD_BITS'(1) << bit_idx;
    assign old_bit  = rd_data_reg[bit_idx];

    assign sts.clr_last  = (clr_addr_reg == WA_W'(NUM_WORDS - 1));
    assign sts.scan_skip = base_in && (&rd_data_reg);
    assign sts.scan_hit  = base_in && hit;
    assign sts.out_free  = !m_valid_reg || out_ready;

    always_comb
    begin
        we = 1'b0;
        wa = clr_addr_reg;
        wd = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (cmd.alloc_commit)
        begin
            we = 1'b1;
            wa = scan_w_reg;
            wd = rd_data_reg | hit_mask;
        end
        else if (cmd.idx_commit && in_range_reg)
        begin
            wa = q_reg;
            case (func_reg)
                sba_pkg::FUNC_RELEASE:
                begin
                    we = 1'b1;
                    wd = rd_data_reg & ~bit_mask;
                end
                sba_pkg::FUNC_MARK:
                begin
                    we = 1'b1;
                    wd = rd_data_reg | bit_mask;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign re = cmd.load || cmd.scan_next;
    assign ra = cmd.load ? ((in_func == sba_pkg::FUNC_ALLOC) ? '0 : q_in)
                         : scan_w_reg + WA_W'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_sectors_reg <= sba_pkg::CFG_RESET;
            clr_addr_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                data_sectors_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + WA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg     <= in_func;
            sector_reg   <= in_sector;
            q_reg        <= q_in;
            in_range_reg <= range_in;
            scan_w_reg   <= '0;
            base_reg     <= '0;
        end
        else if (cmd.scan_next)
        begin
            scan_w_reg <= scan_w_reg + WA_W'(1);
            base_reg   <= base_reg + BASE_W'(WORD_BITS);
        end
    end

    assign out_load = cmd.alloc_commit || cmd.alloc_full || cmd.idx_commit;

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_commit)
        begin
            out_sector_reg <= found_idx[sba_pkg::SECTOR_W-1:0];
            out_ok_reg     <= 1'b1;
            out_used_reg   <= 1'b0;
        end
        else if (cmd.alloc_full)
        begin
            out_sector_reg <= '0;
            out_ok_reg     <= 1'b0;
            out_used_reg   <= 1'b0;
        end
        else if (cmd.idx_commit)
        begin
            out_sector_reg <= sector_reg;
            out_ok_reg     <= in_range_reg;
            out_used_reg   <= in_range_reg && old_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = m_valid_reg;
    assign out_sector   = out_sector_reg;
    assign out_ok       = out_ok_reg;
    assign out_was_used = out_used_reg;

endmodule

// ===== rtl/sector_bitmap_allocator_top.sv =====
// Flow: release, mark and query read the addressed bitmap word, then load
// their result; allocate also skips each full bitmap word it meets first.
// Only one transaction is in flight; the allocate scan reads one bitmap
// word per cycle through the single read port of the bitmap memory.
// Reset: a clearing pass writes zero to all NUM_WORDS bitmap words with
// s_tready low; config writes are taken throughout.
module sector_bitmap_allocator_top
#(
    parameter int NUM_SECTORS = sba_pkg::DEF_NUM_SECTORS,
    parameter int WORD_BITS   = sba_pkg::DEF_WORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sba_pkg::CFG_W-1:0]     cfg_wr_data,   // data_sectors
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sba_pkg::S_TDATA_W-1:0] s_tdata,       // [11:0] sector, rest zero
    input  logic [sba_pkg::S_TUSER_W-1:0] s_tuser,       // [1:0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sba_pkg::M_TDATA_W-1:0] m_tdata,       // [11:0] sector_out, rest zero
    output logic [sba_pkg::M_TUSER_W-1:0] m_tuser        // [0] ok, [1] was_used
);

    sba_pkg::cmd_t cmd;
    sba_pkg::sts_t sts;

    logic [sba_pkg::SECTOR_W-1:0] out_sector;
    logic                         out_ok;
    logic                         out_was_used;

    sba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser[sba_pkg::FUNC_W-1:0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sba_dpath
    #(
        .NUM_SECTORS (NUM_SECTORS),
        .WORD_BITS   (WORD_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_func      (s_tuser[sba_pkg::FUNC_W-1:0]),
        .in_sector    (s_tdata[sba_pkg::SECTOR_W-1:0]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_sector   (out_sector),
        .out_ok       (out_ok),
        .out_was_used (out_was_used),
        .cmd          (cmd),
        .sts          (sts)
    );

    assign m_tdata = sba_pkg::M_TDATA_W'(out_sector);
    assign m_tuser = {out_was_used, out_ok};

endmodule

// ===== rtl/sba_checker.sv =====
// sba_checker: port-level assertions for sector_bitmap_allocator_top,
// attached by the bind below. Depends on sba_pkg for port widths.
module sba_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sba_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sba_pkg::M_TUSER_W-1:0] m_tuser
);

    // no result is presented while reset is held
    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a failed operation never reports the bit as used
    a_fail_not_used: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1])
        else $error("was_used set on failed result");

    // one transaction at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

endmodule

bind sector_bitmap_allocator_top sba_checker u_sba_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
